### rtl/core/dlms_pkg.sv
// dlms_pkg: shared types, codes and helpers for the dense layer engine
// no dependencies; imported by every module of the block but dlms_ram

package dlms_pkg;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int GAIN_BITS  = 16;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 64;
    localparam int DECAY_MULT = 2;

    typedef enum logic [2:0] {
        OP_INPUT,
        OP_GRAD,
        OP_WEIGHT,
        OP_BIAS,
        OP_FORWARD,
        OP_BACKPROP,
        OP_UPDATE,
        OP_CLEAR
    } opcode_t;

    typedef enum logic [1:0] {
        REG_LRATE,
        REG_MOMENTUM,
        REG_DECAY,
        REG_NESTEROV
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_ROW_RD,
        ST_ROW_DAT,
        ST_BIAS,
        ST_EL_RD,
        ST_EL_DAT,
        ST_LOOK,
        ST_MULX,
        ST_ACC,
        ST_EMIT,
        ST_UT,
        ST_US,
        ST_UM,
        ST_UK,
        ST_UW
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] dw;
        logic signed [DATA_W-1:0] w;
    } wentry_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] g;
        logic signed [DATA_W-1:0] db;
        logic signed [DATA_W-1:0] b;
    } ventry_t;

    typedef struct packed {
        logic [GAIN_W-1:0] lr;
        logic [GAIN_W-1:0] mg;
        logic [GAIN_W-1:0] dg;
        logic [GAIN_W-1:0] ng;
    } gains_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = ACC_W'(-64'sd2147483648);
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

    function automatic logic signed [MUL_W-1:0] op_data(input logic signed [DATA_W-1:0] d);
        return {d[DATA_W-1], d};
    endfunction

    function automatic logic signed [MUL_W-1:0] op_gain(input logic [GAIN_W-1:0] g);
        return {{(MUL_W-GAIN_W){1'b0}}, g};
    endfunction

endpackage

### rtl/core/dense_layer_momentum_sgd.sv
// dense_layer_momentum_sgd: dense layer engine with look-ahead forward, backprop and sgd update
// depends on dlms_pkg, dlms_ram, dlms_mul, dlms_ctrl
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata, s_tuser (opcode)
//  m_      | out | m_tvalid/m_tready  | m_tdata, m_tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// writes pass through ST_WR_RD and ST_WR_WB, or stay in idle when the index is out of range;
// forward, backprop and update run times are all set by the one shared multiplier and one ram
// port per element
// reset and clear run a pass zeroing both rams
// a result waits in the output register; the sweep stalls only when a new one is due

module dense_layer_momentum_sgd #(
    parameter int IN_SIZE   = 16,
    parameter int OUT_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row[5:0], col[11:6], value[43:12], zero pad
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value[31:0], result_index[37:32], zero pad
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dlms_pkg::*;

    localparam int WDEPTH = IN_SIZE * OUT_SIZE;
    localparam int VDEPTH = (IN_SIZE > OUT_SIZE) ? IN_SIZE : OUT_SIZE;
    localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int VA     = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

    gains_t gains_reg;

    logic                     w_we, v_we;
    logic [WA-1:0]            w_waddr, w_raddr;
    logic [VA-1:0]            v_waddr, v_raddr;
    wentry_t                  w_wdata, w_rdata;
    ventry_t                  v_wdata, v_rdata;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DATA_W-1:0] m_value;
    logic [IDX_W-1:0]         m_index;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.lr <= 16'd655;
            gains_reg.mg <= '0;
            gains_reg.dg <= '0;
            gains_reg.ng <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_IDX_W'(REG_LRATE))    gains_reg.lr <= cfg_data;
            if (cfg_index == CFG_IDX_W'(REG_MOMENTUM)) gains_reg.mg <= cfg_data;
            if (cfg_index == CFG_IDX_W'(REG_DECAY))    gains_reg.dg <= cfg_data;
            if (cfg_index == CFG_IDX_W'(REG_NESTEROV)) gains_reg.ng <= cfg_data;
        end
    end

    dlms_ram #(.WIDTH($bits(wentry_t)), .DEPTH(WDEPTH), .AW(WA)) u_wram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dlms_ram #(.WIDTH($bits(ventry_t)), .DEPTH(VDEPTH), .AW(VA)) u_vram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    dlms_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    dlms_ctrl #(
        .IN_SIZE   (IN_SIZE),
        .OUT_SIZE  (OUT_SIZE),
        .FRAC_BITS (FRAC_BITS),
        .WA        (WA),
        .VA        (VA)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_op    (opcode_t'(s_tuser)),
        .s_row   (s_tdata[5:0]),
        .s_col   (s_tdata[11:6]),
        .s_value (s_tdata[43:12]),
        .gains   (gains_reg),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_value (m_value),
        .m_index (m_index),
        .m_last  (m_tlast),
        .w_we    (w_we),
        .w_waddr (w_waddr),
        .w_wdata (w_wdata),
        .w_raddr (w_raddr),
        .w_rdata (w_rdata),
        .v_we    (v_we),
        .v_waddr (v_waddr),
        .v_wdata (v_wdata),
        .v_raddr (v_raddr),
        .v_rdata (v_rdata),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .mul_p   (mul_p)
    );

    assign m_tdata = {2'b00, m_index, m_value};

endmodule

### rtl/core/dlms_ram.sv
// dlms_ram: generic single write port, single read port ram, registered read
// no dependencies

module dlms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/dlms_mul.sv
// dlms_mul: shared signed multiplier with registered product
// depends on dlms_pkg

module dlms_mul (
    input  logic                                  aclk,
    input  logic signed [dlms_pkg::MUL_W-1:0]     a,
    input  logic signed [dlms_pkg::MUL_W-1:0]     b,
    output logic signed [dlms_pkg::PROD_W-1:0]    p
);
    import dlms_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### rtl/core/dlms_ctrl.sv
// dlms_ctrl: sequencer and datapath; read-modify-write over the weight and vector rams
// depends on dlms_pkg; drives dlms_ram and dlms_mul instances in the top level

module dlms_ctrl #(
    parameter int IN_SIZE   = 16,
    parameter int OUT_SIZE  = 16,
    parameter int FRAC_BITS = 16,
    parameter int WA        = 8,
    parameter int VA        = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  dlms_pkg::opcode_t                    s_op,
    input  logic [dlms_pkg::IDX_W-1:0]           s_row,
    input  logic [dlms_pkg::IDX_W-1:0]           s_col,
    input  logic signed [dlms_pkg::DATA_W-1:0]   s_value,
    input  dlms_pkg::gains_t                     gains,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [dlms_pkg::DATA_W-1:0]   m_value,
    output logic [dlms_pkg::IDX_W-1:0]           m_index,
    output logic                                 m_last,
    output logic                                 w_we,
    output logic [WA-1:0]                        w_waddr,
    output dlms_pkg::wentry_t                    w_wdata,
    output logic [WA-1:0]                        w_raddr,
    input  dlms_pkg::wentry_t                    w_rdata,
    output logic                                 v_we,
    output logic [VA-1:0]                        v_waddr,
    output dlms_pkg::ventry_t                    v_wdata,
    output logic [VA-1:0]                        v_raddr,
    input  dlms_pkg::ventry_t                    v_rdata,
    output logic signed [dlms_pkg::MUL_W-1:0]    mul_a,
    output logic signed [dlms_pkg::MUL_W-1:0]    mul_b,
    input  logic signed [dlms_pkg::PROD_W-1:0]   mul_p
);
    import dlms_pkg::*;

    localparam int WDEPTH = IN_SIZE * OUT_SIZE;
    localparam int VDEPTH = (IN_SIZE > OUT_SIZE) ? IN_SIZE : OUT_SIZE;

    state_t                   state_reg, state_next;
    opcode_t                  op_reg;
    logic [IDX_W-1:0]         row_reg, col_reg, r_reg, c_reg;
    logic signed [DATA_W-1:0] val_reg, tmp_reg, x_reg;
    logic [WA-1:0]            cnt_reg;
    logic                     bias_reg;
    logic signed [ACC_W-1:0]  acc_reg, s_reg, m_reg, k_reg, ms_reg;
    wentry_t                  wv_reg;
    ventry_t                  row_ent_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic                     out_last_reg;

    logic                     accept, can_load, clr_last, r_last, c_last;
    logic                     inner_last, outer_last, fwd;
    logic                     row_ok, col_ok;
    logic signed [ACC_W-1:0]  pf, pg, wnew;
    logic [WA-1:0]            waddr_rc, waddr_wr;
    logic signed [DATA_W-1:0] t_val;

    assign accept     = s_valid && s_ready;
    assign can_load   = !out_valid_reg || m_ready;
    assign clr_last   = (cnt_reg == WA'(WDEPTH - 1));
    assign r_last     = (r_reg == IDX_W'(OUT_SIZE - 1));
    assign c_last     = (c_reg == IDX_W'(IN_SIZE - 1));
    assign fwd        = (op_reg == OP_FORWARD);
    assign inner_last = fwd ? c_last : r_last;
    assign outer_last = fwd ? r_last : c_last;
    assign row_ok     = int'(s_row) < OUT_SIZE;
    assign col_ok     = int'(s_col) < IN_SIZE;
    assign pf         = ACC_W'(mul_p >>> FRAC_BITS);
    assign pg         = ACC_W'(mul_p >>> GAIN_BITS);
    assign t_val      = sat32(pf);
    assign wnew       = ACC_W'(wv_reg.w) + ms_reg - ACC_W'(DECAY_MULT) * k_reg;
    assign waddr_rc   = WA'(int'(r_reg) * IN_SIZE) + WA'(c_reg);
    assign waddr_wr   = WA'(int'(row_reg) * IN_SIZE) + WA'(col_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:     if (clr_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_op)
                        OP_INPUT:    if (col_ok) state_next = ST_WR_RD;
                        OP_GRAD:     if (row_ok) state_next = ST_WR_RD;
                        OP_BIAS:     if (row_ok) state_next = ST_WR_RD;
                        OP_WEIGHT:   if (row_ok && col_ok) state_next = ST_WR_RD;
                        OP_FORWARD:  state_next = ST_ROW_RD;
                        OP_UPDATE:   state_next = ST_ROW_RD;
                        OP_BACKPROP: state_next = ST_EL_RD;
                        OP_CLEAR:    state_next = ST_CLR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR_RD:   state_next = ST_WR_WB;
            ST_WR_WB:   state_next = ST_IDLE;
            ST_ROW_RD:  state_next = ST_ROW_DAT;
            ST_ROW_DAT: state_next = fwd ? ST_BIAS : ST_EL_RD;
            ST_BIAS:    state_next = ST_EL_RD;
            ST_EL_RD:   state_next = ST_EL_DAT;
            ST_EL_DAT:  state_next = (op_reg == OP_UPDATE) ? ST_UT : ST_LOOK;
            ST_LOOK:    state_next = ST_MULX;
            ST_MULX:    state_next = ST_ACC;
            ST_ACC:     state_next = inner_last ? ST_EMIT : ST_EL_RD;
            ST_EMIT: begin
                if (can_load) begin
                    if (outer_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = fwd ? ST_ROW_RD : ST_EL_RD;
                    end
                end
            end
            ST_UT:      state_next = ST_US;
            ST_US:      state_next = ST_UM;
            ST_UM:      state_next = ST_UK;
            ST_UK:      state_next = ST_UW;
            ST_UW: begin
                if (bias_reg) begin
                    state_next = r_last ? ST_IDLE : ST_ROW_RD;
                end else begin
                    state_next = c_last ? ST_US : ST_EL_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory and multiplier controls
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        w_we    = 1'b0;
        w_waddr = waddr_rc;
        w_wdata = '0;
        w_raddr = waddr_rc;
        v_we    = 1'b0;
        v_waddr = VA'(r_reg);
        v_wdata = '0;
        v_raddr = VA'(r_reg);
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = cnt_reg;
                v_we    = int'(cnt_reg) < VDEPTH;
                v_waddr = VA'(cnt_reg);
            end
            ST_WR_RD: begin
                w_raddr = waddr_wr;
                v_raddr = (op_reg == OP_INPUT) ? VA'(col_reg) : VA'(row_reg);
            end
            ST_WR_WB: begin
                w_we      = (op_reg == OP_WEIGHT);
                w_waddr   = waddr_wr;
                w_wdata.w = val_reg;
                w_wdata.dw = w_rdata.dw;
                v_we      = (op_reg != OP_WEIGHT);
                v_waddr   = (op_reg == OP_INPUT) ? VA'(col_reg) : VA'(row_reg);
                v_wdata   = v_rdata;
                case (op_reg)
                    OP_INPUT: v_wdata.x = val_reg;
                    OP_GRAD:  v_wdata.g = val_reg;
                    OP_BIAS:  v_wdata.b = val_reg;
                    default:  v_wdata   = v_rdata;
                endcase
            end
            ST_ROW_DAT: begin
                mul_a = op_data(v_rdata.db);
                mul_b = op_gain(gains.ng);
            end
            ST_EL_RD: begin
                v_raddr = fwd || (op_reg == OP_UPDATE) ? VA'(c_reg) : VA'(r_reg);
            end
            ST_EL_DAT: begin
                if (op_reg == OP_UPDATE) begin
                    mul_a = op_data(row_ent_reg.g);
                    mul_b = op_data(v_rdata.x);
                end else begin
                    mul_a = op_data(w_rdata.dw);
                    mul_b = op_gain(gains.ng);
                end
            end
            ST_MULX: begin
                mul_a = op_data(tmp_reg);
                mul_b = op_data(x_reg);
            end
            ST_UT: begin
                mul_a = op_data(t_val);
                mul_b = op_gain(gains.lr);
            end
            ST_US: begin
                mul_a = op_data(wv_reg.dw);
                mul_b = op_gain(gains.mg);
            end
            ST_UM: begin
                mul_a = op_data(wv_reg.w);
                mul_b = op_gain(gains.dg);
            end
            ST_UW: begin
                w_we       = !bias_reg;
                w_wdata.w  = sat32(wnew);
                w_wdata.dw = sat32(ms_reg);
                v_we       = bias_reg;
                v_wdata.x  = row_ent_reg.x;
                v_wdata.g  = row_ent_reg.g;
                v_wdata.b  = sat32(wnew);
                v_wdata.db = sat32(ms_reg);
                mul_a      = op_data(row_ent_reg.g);
                mul_b      = op_gain(gains.lr);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            cnt_reg       <= '0;
            bias_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && can_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR: cnt_reg <= cnt_reg + WA'(1);
                ST_IDLE: begin
                    cnt_reg  <= '0;
                    bias_reg <= 1'b0;
                end
                ST_UW: begin
                    if (bias_reg) begin
                        bias_reg <= 1'b0;
                    end else if (c_last) begin
                        bias_reg <= 1'b1;
                    end
                end
                default: bias_reg <= bias_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_reg  <= s_op;
                    row_reg <= s_row;
                    col_reg <= s_col;
                    val_reg <= s_value;
                end
                r_reg   <= '0;
                c_reg   <= '0;
                acc_reg <= '0;
            end
            ST_ROW_DAT: row_ent_reg <= v_rdata;
            ST_BIAS:    acc_reg <= ACC_W'(sat32(ACC_W'(row_ent_reg.b) + pg));
            ST_EL_DAT: begin
                wv_reg <= w_rdata;
                x_reg  <= fwd ? v_rdata.x : v_rdata.g;
            end
            ST_LOOK:    tmp_reg <= sat32(ACC_W'(wv_reg.w) + pg);
            ST_ACC: begin
                acc_reg <= acc_reg + pf;
                if (!inner_last) begin
                    if (fwd) begin
                        c_reg <= c_reg + IDX_W'(1);
                    end else begin
                        r_reg <= r_reg + IDX_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    out_value_reg <= sat32(acc_reg);
                    out_index_reg <= fwd ? r_reg : c_reg;
                    out_last_reg  <= outer_last;
                    if (fwd) begin
                        r_reg <= r_reg + IDX_W'(1);
                        c_reg <= '0;
                    end else begin
                        c_reg <= c_reg + IDX_W'(1);
                        r_reg <= '0;
                    end
                    acc_reg <= '0;
                end
            end
            ST_US: s_reg <= pg;
            ST_UM: m_reg <= pg;
            ST_UK: begin
                k_reg  <= pg;
                ms_reg <= m_reg - s_reg;
            end
            ST_UW: begin
                if (bias_reg) begin
                    r_reg <= r_reg + IDX_W'(1);
                    c_reg <= '0;
                end else if (c_last) begin
                    wv_reg.w  <= row_ent_reg.b;
                    wv_reg.dw <= row_ent_reg.db;
                end else begin
                    c_reg <= c_reg + IDX_W'(1);
                end
            end
            default: tmp_reg <= tmp_reg;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;
    assign m_index = out_index_reg;
    assign m_last  = out_last_reg;

    a_clr_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR && clr_last) |=> state_reg == ST_IDLE)
        else $error("clear pass did not end in idle");
    a_both_we: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_we && v_we) |-> state_reg == ST_CLR)
        else $error("both rams written outside clear");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && can_load && outer_last) |=> state_reg == ST_IDLE)
        else $error("sequencer kept running after last result");
    a_no_we_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(w_we || v_we))
        else $error("ram written while idle");

endmodule

### tb/tb.sv
// tb: self-checking testbench for the dense layer engine with momentum sgd
// depends on dlms_pkg and dense_layer_momentum_sgd; predicts every result in-line
`timescale 1ns / 100ps

module tb;
    import dlms_pkg::*;

    localparam int NIN      = 16;
    localparam int NOUT     = 16;
    localparam int FRAC     = 16;
    localparam int DRAIN    = 2500;
    localparam int HOLD_LEN = 3000;
    localparam logic [7:0] CFG_IDX_UNUSED = 8'd200;

    typedef struct {
        int          val;
        logic [5:0]  idx;
        logic        last;
    } result_t;

    typedef struct {
        opcode_t     op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] val;
        bit          zero_known;
    } request_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    dense_layer_momentum_sgd #(.IN_SIZE(NIN), .OUT_SIZE(NOUT), .FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // layer model state
    int          wt [NOUT*NIN];
    int          wd [NOUT*NIN];
    int          bs [NOUT];
    int          bd [NOUT];
    int          gr [NOUT];
    int          xv [NIN];
    int unsigned lr, mg, dg, ng;

    result_t  pending_results[$];
    request_t directed[$];
    int       mismatches;
    bit       quiet;
    bit       hold_req;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int sat(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic longint gain_prod(int v, int unsigned g);
        return (longint'(v) * longint'(g)) >>> GAIN_BITS;
    endfunction

    function automatic longint data_prod(int a, int b);
        return (longint'(a) * longint'(b)) >>> FRAC;
    endfunction

    function automatic int look_w(int r, int c);
        return sat(longint'(wt[r*NIN+c]) + gain_prod(wd[r*NIN+c], ng));
    endfunction

    task automatic clear_layer();
        for (int i = 0; i < NOUT*NIN; i++) begin
            wt[i] = 0;
            wd[i] = 0;
        end
        for (int i = 0; i < NOUT; i++) begin
            bs[i] = 0;
            bd[i] = 0;
            gr[i] = 0;
        end
        for (int i = 0; i < NIN; i++) xv[i] = 0;
    endtask

    task automatic sgd_step(inout int w, inout int d, input int t);
        longint s, m, k;
        s = gain_prod(t, lr);
        m = gain_prod(d, mg);
        k = DECAY_MULT * gain_prod(w, dg);
        d = sat(m - s);
        w = sat(longint'(w) + m - s - k);
    endtask

    task automatic predict_layer(request_t q);
        longint  acc;
        int      v;
        result_t e;
        v = int'(q.val);
        case (q.op)
            OP_INPUT: if (q.col < NIN) xv[q.col] = v;
            OP_GRAD: if (q.row < NOUT) gr[q.row] = v;
            OP_WEIGHT: if (q.row < NOUT && q.col < NIN) wt[q.row*NIN+q.col] = v;
            OP_BIAS: if (q.row < NOUT) bs[q.row] = v;
            OP_FORWARD: begin
                for (int r = 0; r < NOUT; r++) begin
                    acc = sat(longint'(bs[r]) + gain_prod(bd[r], ng));
                    for (int c = 0; c < NIN; c++) acc += data_prod(look_w(r, c), xv[c]);
                    e.val = q.zero_known ? 0 : sat(acc);
                    e.idx = 6'(r);
                    e.last = (r == NOUT-1);
                    pending_results.push_back(e);
                end
            end
            OP_BACKPROP: begin
                for (int c = 0; c < NIN; c++) begin
                    acc = 0;
                    for (int r = 0; r < NOUT; r++) acc += data_prod(look_w(r, c), gr[r]);
                    e.val = q.zero_known ? 0 : sat(acc);
                    e.idx = 6'(c);
                    e.last = (c == NIN-1);
                    pending_results.push_back(e);
                end
            end
            OP_UPDATE: begin
                for (int r = 0; r < NOUT; r++) begin
                    for (int c = 0; c < NIN; c++)
                        sgd_step(wt[r*NIN+c], wd[r*NIN+c], sat(data_prod(gr[r], xv[c])));
                    sgd_step(bs[r], bd[r], gr[r]);
                end
            end
            default: clear_layer();
        endcase
    endtask

    task automatic send_request(request_t q);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {4'b0, q.val, q.col, q.row};
        s_tuser <= q.op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_layer(q);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            8'(REG_LRATE): lr = data;
            8'(REG_MOMENTUM): mg = data;
            8'(REG_DECAY): dg = data;
            8'(REG_NESTEROV): ng = data;
            default: ;
        endcase
    endtask

    task automatic add_row(opcode_t op, int row, int col, logic [31:0] val, bit z);
        request_t q;
        q.op = op;
        q.row = 6'(row);
        q.col = 6'(col);
        q.val = val;
        q.zero_known = z;
        directed.push_back(q);
    endtask

    function automatic logic [31:0] rand_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 32'($urandom_range(0, 262143)) - 32'd131072;
        if (pick < 85) return 32'($urandom_range(0, 33554431)) - 32'd16777216;
        return $urandom;
    endfunction

    function automatic request_t rand_request();
        request_t q;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) q.op = OP_INPUT;
        else if (pick < 40) q.op = OP_GRAD;
        else if (pick < 62) q.op = OP_WEIGHT;
        else if (pick < 78) q.op = OP_BIAS;
        else if (pick < 87) q.op = OP_FORWARD;
        else if (pick < 94) q.op = OP_BACKPROP;
        else if (pick < 99) q.op = OP_UPDATE;
        else q.op = OP_CLEAR;
        q.row = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
        q.col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
        q.val = rand_value();
        q.zero_known = 1'b0;
        return q;
    endfunction

    // result checker
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value %h index %0d", m_tdata[31:0],
                             m_tdata[37:32]);
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[31:0] !== e.val || m_tdata[37:32] !== e.idx
                        || m_tlast !== e.last || m_tdata[39:38] !== 2'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h/%0d/%0d got %h/%0d/%0d", e.val, e.idx,
                                 e.last, m_tdata[31:0], m_tdata[37:32], m_tlast);
                end
            end
        end
    end

    // receiver
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // stimulus
    initial begin
        request_t q;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        aresetn = 1'b0;
        mismatches = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        lr = 655;
        mg = 0;
        dg = 0;
        ng = 0;
        clear_layer();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: stores all zero after reset, extremes, ignored indexes, clear
        add_row(OP_FORWARD, 0, 0, 32'h0, 1);
        add_row(OP_BACKPROP, 0, 0, 32'h0, 1);
        add_row(OP_INPUT, 0, 0, 32'h7fffffff, 0);
        add_row(OP_INPUT, 0, 15, 32'h80000000, 0);
        add_row(OP_INPUT, 0, 16, 32'h12345678, 0);
        add_row(OP_INPUT, 63, 63, 32'hffffffff, 0);
        add_row(OP_GRAD, 0, 0, 32'h7fffffff, 0);
        add_row(OP_GRAD, 15, 0, 32'h80000000, 0);
        add_row(OP_GRAD, 63, 0, 32'h00010000, 0);
        add_row(OP_WEIGHT, 0, 0, 32'h7fffffff, 0);
        add_row(OP_WEIGHT, 15, 15, 32'h80000000, 0);
        add_row(OP_WEIGHT, 16, 0, 32'h00010000, 0);
        add_row(OP_WEIGHT, 0, 16, 32'h00010000, 0);
        add_row(OP_BIAS, 0, 0, 32'h7fffffff, 0);
        add_row(OP_BIAS, 15, 0, 32'h80000000, 0);
        add_row(OP_BIAS, 40, 0, 32'h00020000, 0);
        add_row(OP_FORWARD, 0, 0, 32'h0, 0);
        add_row(OP_BACKPROP, 0, 0, 32'h0, 0);
        add_row(OP_UPDATE, 0, 0, 32'h0, 0);
        add_row(OP_FORWARD, 0, 0, 32'h0, 0);
        add_row(OP_BACKPROP, 0, 0, 32'h0, 0);
        add_row(OP_CLEAR, 0, 0, 32'h0, 0);
        add_row(OP_FORWARD, 0, 0, 32'h0, 1);
        foreach (directed[i]) send_request(directed[i]);

        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_reg(8'(REG_LRATE), 16'hffff);
                    write_reg(8'(REG_MOMENTUM), 16'hffff);
                    write_reg(8'(REG_DECAY), 16'hffff);
                    write_reg(8'(REG_NESTEROV), 16'hffff);
                end
                1: begin
                    quiet = 1'b1;
                    write_reg(8'(REG_LRATE), 16'h0);
                    write_reg(8'(REG_MOMENTUM), 16'h0);
                    write_reg(8'(REG_DECAY), 16'h0);
                    write_reg(8'(REG_NESTEROV), 16'h0);
                end
                2: begin
                    quiet = 1'b0;
                    write_reg(CFG_IDX_UNUSED, 16'h1234);
                    write_reg(8'(REG_LRATE), 16'd8192);
                    write_reg(8'(REG_MOMENTUM), 16'd58982);
                    write_reg(8'(REG_DECAY), 16'd64);
                    write_reg(8'(REG_NESTEROV), 16'd58982);
                end
                default: begin
                    write_reg(8'(REG_LRATE), 16'($urandom));
                    write_reg(8'(REG_MOMENTUM), 16'($urandom));
                    write_reg(8'(REG_DECAY), 16'($urandom_range(0, 2047)));
                    write_reg(8'(REG_NESTEROV), 16'($urandom));
                end
            endcase
            if (phase == 2) begin
                hold_req = 1'b1;
                q = rand_request();
                q.op = OP_FORWARD;
                repeat (3) send_request(q);
            end
            for (int n = 0; n < 47; n++) send_request(rand_request());
        end

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/dlms_pkg.sv
rtl/core/dlms_ram.sv
rtl/core/dlms_mul.sv
rtl/core/dlms_ctrl.sv
rtl/core/dense_layer_momentum_sgd.sv
tb/tb.sv
